// ----- rtl/smjt_pkg.sv -----
// smjt_pkg: shared types, register codes, widths and saturation helpers
// for the sliding-mode joint torque block
// no dependencies
`default_nettype none

package smjt_pkg;

   // joint count default and field widths
   localparam int JOINTS_DEF = 7;
   localparam int JOINT_W    = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_W      = 24;
   localparam int GAIN_W     = 24;
   localparam int PERIOD_W   = 17;
   localparam int DECAY_W    = 17;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 25;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POSITION_GAIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRAL_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD_LENGTH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_FACTOR  = 3'd4;

   // register reset values
   localparam logic [GAIN_W-1:0]   POSITION_GAIN_RST = 24'd983040;
   localparam logic [GAIN_W-1:0]   INTEGRAL_GAIN_RST = 24'd98304;
   localparam logic [GAIN_W-1:0]   DAMPING_GAIN_RST  = 24'd1638400;
   localparam logic [PERIOD_W-1:0] PERIOD_LENGTH_RST = 17'd66;
   localparam logic [DECAY_W-1:0]  DECAY_FACTOR_RST  = 17'd65470;

   // decay limits, one in q1.16 and the ceiling
   localparam logic [DECAY_W-1:0] DECAY_ONE = 17'd65536;
   localparam logic [DECAY_W-1:0] DECAY_MAX = 17'd131071;

   // signed 32 bit limits at 64 bit width
   localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [JOINT_W-1:0] joint_index;
      logic               restart;
      logic signed [31:0] measured_position;
      logic signed [31:0] measured_velocity;
      logic signed [31:0] desired_position;
      logic signed [31:0] desired_velocity;
   } req_type;

   typedef struct packed {
      logic [JOINT_W-1:0] torque_joint;
      logic signed [31:0] torque_command;
      logic               saturated;
   } rsp_type;

   // clamp to the signed 32 bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > S32_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (x < S32_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = 32'(x);
      end
      return r;
   endfunction

   // flag a value outside the signed 32 bit range
   function automatic logic over32(input logic signed [63:0] x);
      return (x > S32_MAX) || (x < S32_MIN);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/smjt_mul.sv -----
// smjt_mul: shared signed multiplier with a registered product
// depends on smjt_pkg for operand widths
`default_nettype none

module smjt_mul (
   input  wire logic                                clock,
   input  wire logic signed [smjt_pkg::MUL_A_W-1:0] mul_a,
   input  wire logic signed [smjt_pkg::MUL_B_W-1:0] mul_b,
   output logic signed [smjt_pkg::MUL_P_W-1:0]      prod_ff
);
   import smjt_pkg::*;

   logic signed [MUL_P_W-1:0] prod_in;

   // full product of the selected operands
   always_comb begin
      prod_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   end

   // product register
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ----- rtl/sliding_mode_joint_torque.sv -----
// sliding_mode_joint_torque: top level, sequencer, joint state and registers
// depends on smjt_pkg and smjt_mul
//
// Usage
//   req channel: one beat is one joint sample (joint index, restart mark,
//   measured and desired position and velocity, q16.16). A beat is taken when
//   req_valid is high and req_stall is low.
//   rsp channel: one beat per sample with a joint index inside the joint
//   count: joint, torque command (q16.16, saturated) and saturation flag.
//   Samples for a joint index at or above JOINTS are taken and dropped.
//   csr port: csr_we writes csr_wdata to register csr_index, one per cycle;
//   the user must write only while the block is idle, the block does not enforce it.
// Sequencing
//   All products run through one multiplier, one per sequencer step; a
//   sample runs through its steps from its accept to the result register,
//   and the block takes no new sample before the last one is loaded there.
//   req_stall is high whenever a sample is in work.
// Reset
//   Synchronous, active high: configuration registers back to their defaults, every
//   joint uncaptured with decay at one, no result pending.
// Receiver stall
//   The result register holds while rsp_stall is high; a later sample runs
//   through its steps and then waits for the register to empty.
`default_nettype none

module sliding_mode_joint_torque #(
   parameter int JOINTS = smjt_pkg::JOINTS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire smjt_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output smjt_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [smjt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [smjt_pkg::CSR_W-1:0]        csr_wdata
);
   import smjt_pkg::*;

   localparam int IDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_S,
      S_ADD_S,
      S_MUL_D,
      S_ADD_Q,
      S_MUL_I,
      S_ADD_R,
      S_MUL_H,
      S_MUL_L,
      S_ADD_T,
      S_ADD_N,
      S_OUT
   } state_type;

   // configuration registers
   logic [GAIN_W-1:0]   position_gain_ff;
   logic [GAIN_W-1:0]   integral_gain_ff;
   logic [GAIN_W-1:0]   damping_gain_ff;
   logic [PERIOD_W-1:0] period_length_ff;
   logic [DECAY_W-1:0]  decay_factor_ff;

   // per joint state
   logic signed [31:0]  reference_ff [JOINTS];
   logic [DECAY_W-1:0]  decay_ff     [JOINTS];
   logic signed [31:0]  integral_ff  [JOINTS];
   logic                captured_ff  [JOINTS];

   // sequencer and working registers
   state_type             state_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [JOINT_W-1:0]    joint_ff;
   logic                  restart_ff;
   logic signed [32:0]    ep_ff;
   logic signed [32:0]    ev_ff;
   logic signed [31:0]    s_ff;
   logic                  cap_ff;
   logic signed [31:0]    ref_w_ff;
   logic [DECAY_W-1:0]    dec_w_ff;
   logic signed [31:0]    int_w_ff;
   logic signed [35:0]    q_ff;
   logic                  hit_ff;
   logic signed [25:0]    hi_ff;
   logic [15:0]           lo_ff;
   logic signed [49:0]    p1_ff;
   logic signed [31:0]    t_ff;
   logic [DECAY_W-1:0]    nd_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod_ff;

   // combinational step results
   logic                  in_range;
   logic                  accept;
   logic                  out_free;
   logic signed [43:0]    s_sum;
   logic signed [31:0]    s_in;
   logic                  cap_in;
   logic signed [35:0]    q_in;
   logic signed [33:0]    int_sum;
   logic signed [31:0]    int_in;
   logic                  int_hit;
   logic signed [41:0]    sr_in;
   logic signed [51:0]    t_sum;
   logic signed [51:0]    t_neg;
   logic [17:0]           nd_full;
   logic [DECAY_W-1:0]    nd_in;

   smjt_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // handshake
   assign in_range  = int'(req_data.joint_index) < JOINTS;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // operand selection for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MUL_S: begin
            mul_a = MUL_A_W'(ep_ff);
            mul_b = $signed({1'b0, position_gain_ff});
         end
         S_MUL_D: begin
            mul_a = MUL_A_W'(ref_w_ff);
            mul_b = $signed({(MUL_B_W - DECAY_W)'(0), dec_w_ff});
         end
         S_MUL_I: begin
            mul_a = MUL_A_W'(int_w_ff);
            mul_b = $signed({1'b0, integral_gain_ff});
         end
         S_MUL_H: begin
            mul_a = MUL_A_W'(hi_ff);
            mul_b = $signed({1'b0, damping_gain_ff});
         end
         S_MUL_L: begin
            mul_a = $signed({(MUL_A_W - 16)'(0), lo_ff});
            mul_b = $signed({1'b0, damping_gain_ff});
         end
         S_ADD_T: begin
            mul_a = $signed({(MUL_A_W - DECAY_W)'(0), dec_w_ff});
            mul_b = $signed({(MUL_B_W - DECAY_W)'(0), decay_factor_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // surface, difference, integral, torque and decay arithmetic
   always_comb begin
      s_sum   = 44'(ev_ff) + 44'(prod_ff >>> 16);
      s_in    = sat32(64'(s_sum));
      cap_in  = restart_ff || !captured_ff[idx_ff];
      q_in    = 36'(s_ff) - 36'(prod_ff >>> 16);
      if (q_in > 36'sd0) begin
         int_sum = 34'(int_w_ff) + $signed({17'd0, period_length_ff});
      end else if (q_in < 36'sd0) begin
         int_sum = 34'(int_w_ff) - $signed({17'd0, period_length_ff});
      end else begin
         int_sum = 34'(int_w_ff);
      end
      int_in  = sat32(64'(int_sum));
      int_hit = over32(64'(int_sum));
      sr_in   = 42'(q_ff) + 42'(prod_ff >>> 16);
      t_sum   = 52'(p1_ff) + 52'(prod_ff >>> 16);
      t_neg   = -t_sum;
      nd_full = prod_ff[33:16];
      nd_in   = (nd_full > 18'(DECAY_MAX)) ? DECAY_MAX : nd_full[DECAY_W-1:0];
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         position_gain_ff <= POSITION_GAIN_RST;
         integral_gain_ff <= INTEGRAL_GAIN_RST;
         damping_gain_ff  <= DAMPING_GAIN_RST;
         period_length_ff <= PERIOD_LENGTH_RST;
         decay_factor_ff  <= DECAY_FACTOR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_POSITION_GAIN: position_gain_ff <= csr_wdata;
            CSR_INTEGRAL_GAIN: integral_gain_ff <= csr_wdata;
            CSR_DAMPING_GAIN:  damping_gain_ff  <= csr_wdata;
            CSR_PERIOD_LENGTH: period_length_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_DECAY_FACTOR:  decay_factor_ff  <= csr_wdata[DECAY_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer with working registers, joint state write-back and result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < JOINTS; i++) begin
            reference_ff[i] <= '0;
            decay_ff[i]     <= DECAY_ONE;
            integral_ff[i]  <= '0;
            captured_ff[i]  <= 1'b0;
         end
      end else begin
         // result register empties here unless a new beat is loaded below
         if (rsp_valid_ff && !rsp_stall && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept && in_range) begin
                  idx_ff     <= IDX_W'(req_data.joint_index);
                  joint_ff   <= req_data.joint_index;
                  restart_ff <= req_data.restart;
                  ep_ff      <= 33'(req_data.measured_position)
                                - 33'(req_data.desired_position);
                  ev_ff      <= 33'(req_data.measured_velocity)
                                - 33'(req_data.desired_velocity);
                  state_ff   <= S_MUL_S;
               end
            end
            S_MUL_S: state_ff <= S_ADD_S;
            S_ADD_S: begin
               s_ff     <= s_in;
               cap_ff   <= cap_in;
               ref_w_ff <= cap_in ? s_in : reference_ff[idx_ff];
               dec_w_ff <= cap_in ? DECAY_ONE : decay_ff[idx_ff];
               int_w_ff <= cap_in ? 32'sd0 : integral_ff[idx_ff];
               state_ff <= S_MUL_D;
            end
            S_MUL_D: state_ff <= S_ADD_Q;
            S_ADD_Q: begin
               // integral step on the sign of the difference
               q_ff     <= q_in;
               int_w_ff <= int_in;
               hit_ff   <= int_hit;
               state_ff <= S_MUL_I;
            end
            S_MUL_I: state_ff <= S_ADD_R;
            S_ADD_R: begin
               hi_ff    <= 26'(sr_in >>> 16);
               lo_ff    <= sr_in[15:0];
               state_ff <= S_MUL_H;
            end
            S_MUL_H: state_ff <= S_MUL_L;
            S_MUL_L: begin
               p1_ff    <= 50'(prod_ff);
               state_ff <= S_ADD_T;
            end
            S_ADD_T: begin
               t_ff     <= sat32(64'(t_neg));
               hit_ff   <= hit_ff || over32(64'(t_neg));
               state_ff <= S_ADD_N;
            end
            S_ADD_N: begin
               nd_ff    <= nd_in;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_ff.torque_joint   <= joint_ff;
                  rsp_ff.torque_command <= t_ff;
                  rsp_ff.saturated      <= hit_ff;
                  rsp_valid_ff          <= 1'b1;
                  reference_ff[idx_ff]  <= ref_w_ff;
                  decay_ff[idx_ff]      <= nd_ff;
                  integral_ff[idx_ff]   <= int_w_ff;
                  captured_ff[idx_ff]   <= 1'b1;
                  state_ff              <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // no result pending straight after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid_ff)
      else $error("result pending after reset");

   // a capture period gives a zero integral and a zero torque
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && cap_ff) |-> (int_w_ff == 32'sd0 && t_ff == 32'sd0))
      else $error("capture period with non-zero integral or torque");

   // a finished sample reaches the result register once it is free
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished sample not delivered");

   // a beat for a joint outside the joint count starts no work
   assert property (@(posedge clock) disable iff (reset)
      (accept && !in_range) |=> (state_ff == S_IDLE))
      else $error("out of range joint started work");

endmodule

`default_nettype wire
